/* hdl/crm_pkg.sv */
// Package for the per-class byte rate meter.
// Holds the transaction types, command codes and constants; no dependencies.
`default_nettype none
package crm_pkg;

    localparam int unsigned DW = 64;
    localparam logic [DW-1:0] NS_PER_SEC = 64'd1000000000;
    localparam logic [DW-1:0] PERIOD_RESET = 64'd30000000000;
    localparam logic [DW-1:0] ALL_ONES = {DW{1'b1}};

    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_TRACK = 1'b1;
    localparam logic STATUS_REPORT = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    localparam logic [1:0] OP_PACKET = 2'd0;
    localparam logic [1:0] OP_TRACK = 2'd1;
    localparam logic [1:0] OP_REJECT = 2'd2;

    typedef struct packed {
        logic          kind;
        logic [63:0]   class_id;
        logic [15:0]   packet_bytes;
        logic [63:0]   now_ns;
    } t_in_item;

    typedef struct packed {
        logic          status;
        logic [63:0]   report_class;
        logic [63:0]   rate_bytes_per_s;
    } t_out_item;

    typedef struct packed {
        logic [1:0]    op;
        logic [63:0]   class_id;
        logic [15:0]   packet_bytes;
        logic [63:0]   now_ns;
    } t_cmd;

endpackage
`default_nettype wire

/* hdl/per_class_byte_rate_meter.sv */
// Per-class byte rate meter top level. After acceptance the back end pops the command,
// then reads and compares table entries one at a time, with a miss step when none matches;
// a reject goes to the output state. A report first works out the elapsed seconds,
// then, unless they are zero, runs a serial 64-step rate division, then drives the output.
// Transactions are handled one at a time, so a new one waits until the last is through;
// the linear scan dominates. Reset (synchronous, active low) empties the table through its fill count.
`default_nettype none
module per_class_byte_rate_meter
    import crm_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 1024
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [DW-1:0] i_cfg_data,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire t_in_item      i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output t_out_item          o_out_data
);

    logic [DW-1:0] r_period;
    logic          q_valid, q_pop;
    t_cmd          q_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (i_cfg_valid) begin
            r_period <= i_cfg_data;
        end
    end

    crm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_q_valid  (q_valid),
        .i_q_pop    (q_pop),
        .o_q_data   (q_data)
    );

    crm_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_period    (r_period),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_q_data    (q_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

/* hdl/crm_front.sv */
// Front end: accepts input transactions, classifies them and queues commands.
// Depends on crm_pkg.
`default_nettype none
module crm_front
    import crm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_data,
    output logic          o_q_valid,
    input  wire logic     i_q_pop,
    output t_cmd          o_q_data
);

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;
    t_cmd       cmd;

    always_comb begin
        cmd.class_id = i_in_data.class_id;
        cmd.packet_bytes = i_in_data.packet_bytes;
        cmd.now_ns = i_in_data.now_ns;
        if (i_in_data.kind == KIND_TRACK) begin
            cmd.op = (i_in_data.class_id == '0) ? OP_REJECT : OP_TRACK;
        end else begin
            cmd.op = OP_PACKET;
        end
    end

    assign o_in_ready = (r_cnt != 2'd2);
    // Packets of class zero are dropped here and never reach the table.
    assign push = i_in_valid && o_in_ready &&
                  !(i_in_data.kind == KIND_PACKET && i_in_data.class_id == '0);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_data = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end

endmodule
`default_nettype wire

/* hdl/crm_div.sv */
// Restoring divider, one quotient bit per cycle, with a 64-bit quotient.
// Depends on crm_pkg.
`default_nettype none
module crm_div
    import crm_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [DW-1:0] i_divisor,
    output logic               o_busy,
    output logic               o_done,
    output logic [DW-1:0]      o_quotient
);

    logic [DW-1:0] r_rem, r_quo, r_dvs;
    logic [5:0]    r_cnt;
    logic          r_busy, r_done;
    logic [DW:0]   shifted, diff;

    assign shifted = {r_rem, r_quo[DW-1]};
    assign diff = shifted - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!diff[DW]) begin
                r_rem <= diff[DW-1:0];
            end else begin
                r_rem <= shifted[DW-1:0];
            end
            r_quo <= {r_quo[DW-2:0], ~diff[DW]};
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= 6'd63;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

/* hdl/crm_back.sv */
// Back end: scans the class table, updates totals and produces reports.
// Depends on crm_pkg and crm_div.
`default_nettype none
module crm_back
    import crm_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 1024
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [DW-1:0] i_period,
    input  wire logic          i_q_valid,
    output logic               o_q_pop,
    input  wire t_cmd          i_q_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output t_out_item          o_out_data
);

    localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

    // One second is 2^9 * 5^9 ns. The elapsed time is shifted right by nine and
    // multiplied by ceil(2^76 / 5^9); bits 76 and up of the product are the seconds.
    localparam logic [55:0] SEC_RECIP = 56'd38685626227668134;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_MISS = 3'd3;
    localparam logic [2:0] S_SEC  = 3'd4;
    localparam logic [2:0] S_DIV2 = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [DW-1:0] class_mem [TABLE_ENTRIES];
    logic [DW-1:0] total_mem [TABLE_ENTRIES];
    logic [DW-1:0] stamp_mem [TABLE_ENTRIES];

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_count, n_count;
    t_cmd          r_cmd, n_cmd;
    logic [DW-1:0] r_sum, n_sum;
    t_out_item     r_out, n_out;
    logic [DW-1:0] r_rd_class, r_rd_total, r_rd_stamp;
    logic [54:0]   r_x, n_x;
    logic [57:0]   r_acc, n_acc;
    logic [1:0]    r_sstep, n_sstep;

    logic          we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] w_total, w_stamp;
    logic [DW:0]   sum_wide;
    logic [DW-1:0] sum_sat, delta;
    logic [27:0]   mul_a, mul_b;
    logic [55:0]   pp;
    logic [57:0]   acc_sum;
    logic [DW-1:0] secs;
    logic          div_start, div_busy, div_done;
    logic [DW-1:0] div_dividend, div_divisor, div_quo;

    crm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign sum_wide = {1'b0, r_rd_total} + {{(DW-15){1'b0}}, r_cmd.packet_bytes};
    assign sum_sat = sum_wide[DW] ? ALL_ONES : sum_wide[DW-1:0];
    assign delta = r_cmd.now_ns - r_rd_stamp;

    // Four 28 by 28 partial products, lowest weight first, one per cycle.
    assign mul_a = r_sstep[1] ? {1'b0, r_x[54:28]} : r_x[27:0];
    assign mul_b = r_sstep[0] ? SEC_RECIP[55:28] : SEC_RECIP[27:0];
    assign pp = 56'(mul_a) * 56'(mul_b);
    assign acc_sum = r_acc + {2'b0, pp};
    assign secs = {26'b0, acc_sum[57:20]};

    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        n_count = r_count;
        n_cmd = r_cmd;
        n_sum = r_sum;
        n_out = r_out;
        n_x = r_x;
        n_acc = r_acc;
        n_sstep = r_sstep;
        o_q_pop = 1'b0;
        we = 1'b0;
        waddr = r_idx;
        w_total = '0;
        w_stamp = r_cmd.now_ns;
        div_start = 1'b0;
        div_dividend = r_sum;
        div_divisor = secs;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd = i_q_data;
                    n_idx = '0;
                    if (i_q_data.op == OP_REJECT) begin
                        n_out = '{STATUS_REJECT, '0, '0};
                        n_state = S_OUT;
                    end else if (r_count == '0) begin
                        n_state = S_MISS;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: n_state = S_CMP;
            S_CMP: begin
                if (r_rd_class == r_cmd.class_id) begin
                    we = 1'b1;
                    n_state = S_IDLE;
                    if (r_cmd.op == OP_PACKET) begin
                        if (r_cmd.now_ns > r_rd_stamp && delta >= i_period) begin
                            n_sum = sum_sat;
                            n_x = delta[63:9];
                            n_sstep = '0;
                            n_state = S_SEC;
                        end else begin
                            w_total = sum_sat;
                            w_stamp = r_rd_stamp;
                        end
                    end
                end else if (CW'(r_idx) + CW'(1) == r_count) begin
                    n_state = S_MISS;
                end else begin
                    n_idx = r_idx + AW'(1);
                    n_state = S_RD;
                end
            end
            S_MISS: begin
                n_state = S_IDLE;
                if (r_cmd.op == OP_TRACK) begin
                    if (r_count < CW'(TABLE_ENTRIES)) begin
                        we = 1'b1;
                        waddr = AW'(r_count);
                        n_count = r_count + CW'(1);
                    end else begin
                        n_out = '{STATUS_REJECT, r_cmd.class_id, '0};
                        n_state = S_OUT;
                    end
                end
            end
            S_SEC: begin
                n_sstep = r_sstep + 2'd1;
                case (r_sstep)
                    2'd0: n_acc = {30'b0, pp[55:28]};
                    2'd2: n_acc = acc_sum >> 28;
                    default: n_acc = acc_sum;
                endcase
                if (r_sstep == 2'd3) begin
                    if (secs == '0) begin
                        n_out = '{STATUS_REPORT, r_cmd.class_id, ALL_ONES};
                        n_state = S_OUT;
                    end else begin
                        div_start = 1'b1;
                        n_state = S_DIV2;
                    end
                end
            end
            S_DIV2: begin
                if (div_done) begin
                    n_out = '{STATUS_REPORT, r_cmd.class_id, div_quo};
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            class_mem[waddr] <= r_cmd.class_id;
            total_mem[waddr] <= w_total;
            stamp_mem[waddr] <= w_stamp;
        end
        r_rd_class <= class_mem[r_idx];
        r_rd_total <= total_mem[r_idx];
        r_rd_stamp <= stamp_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_sum <= n_sum;
        r_out <= n_out;
        r_x <= n_x;
        r_acc <= n_acc;
        r_sstep <= n_sstep;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
            r_count <= n_count;
        end
    end

    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data = r_out;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_ENTRIES))
        else $error("table fill count exceeds table size");
    a_div_idle_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");
    a_reject_rate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == STATUS_REJECT)
            |-> o_out_data.rate_bytes_per_s == '0)
        else $error("reject carries a nonzero rate");
    a_no_pop_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> r_state == S_IDLE)
        else $error("command popped outside idle");
`endif

endmodule
`default_nettype wire
